>>> src/rfa_pkg.sv
// Package for the rational fraction ALU: operation codes, back-end states,
// the queued item type and value limits.
// Used by every module of the block; depends on nothing.
package rfa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NUM_W = 32;
  localparam int DEN_W = 31;
  localparam int OPD_W = 33;
  localparam int PROD_W = 64;
  localparam int QUEUE_DEPTH = 2;

  // Largest magnitude of a result denominator or positive numerator; a negative one may be one more.
  localparam logic [PROD_W-1:0] LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_LT  = 3'd5,
    OP_LE  = 3'd6,
    OP_EQ  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } back_state_t;

  // One classified item: three product operand pairs plus control.
  typedef struct packed {
    op_t              op;
    logic             div_zero;
    logic [OPD_W-1:0] x0;
    logic [OPD_W-1:0] y0;
    logic [OPD_W-1:0] x1;
    logic [OPD_W-1:0] y1;
    logic [OPD_W-1:0] x2;
    logic [OPD_W-1:0] y2;
  } item_t;

endpackage

>>> src/rfa_front.sv
// Front end of the rational fraction ALU: decodes an item and chooses the
// operands of the three products the back end forms.
// Depends on rfa_pkg.
module rfa_front (
  input  logic [2:0]                  in_kind,
  input  logic [rfa_pkg::NUM_W-1:0]   in_a_num,
  input  logic [rfa_pkg::DEN_W-1:0]   in_a_den,
  input  logic [rfa_pkg::NUM_W-1:0]   in_b_num,
  input  logic [rfa_pkg::DEN_W-1:0]   in_b_den,
  output rfa_pkg::item_t              item
);

  logic [rfa_pkg::OPD_W-1:0] an, bn, ad, bd, one, minus_one, zero;

  always_comb begin
    an = {in_a_num[rfa_pkg::NUM_W-1], in_a_num};
    bn = {in_b_num[rfa_pkg::NUM_W-1], in_b_num};
    // A zero denominator is taken as one.
    ad = (in_a_den == '0) ? rfa_pkg::OPD_W'(1) : {2'b00, in_a_den};
    bd = (in_b_den == '0) ? rfa_pkg::OPD_W'(1) : {2'b00, in_b_den};
    one = rfa_pkg::OPD_W'(1);
    minus_one = '1;
    zero = '0;

    item.op = rfa_pkg::op_t'(in_kind);
    item.div_zero = 1'b0;
    item.x0 = an;
    item.y0 = bd;
    item.x1 = bn;
    item.y1 = ad;
    item.x2 = ad;
    item.y2 = bd;
    case (item.op)
      rfa_pkg::OP_MUL: begin
        item.y0 = bn;
        item.x1 = zero;
        item.y1 = zero;
      end
      rfa_pkg::OP_DIV: begin
        item.y2 = bn;
        item.div_zero = (in_b_num == '0);
      end
      rfa_pkg::OP_NEG: begin
        item.y0 = minus_one;
        item.y2 = one;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/rfa_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on rfa_pkg.
module rfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rfa_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rfa_pkg::item_t head
);

  localparam int AW = $clog2(rfa_pkg::QUEUE_DEPTH);

  rfa_pkg::item_t mem [rfa_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign full = (count_r == (AW+1)'(rfa_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(rfa_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("pop from an empty queue");

endmodule

>>> src/rfa_back.sv
// Back end of the rational fraction ALU: products, binary gcd, exact
// reduction by two shift-subtract dividers, and the result register.
// Depends on rfa_pkg.
module rfa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  rfa_pkg::item_t              q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfa_pkg::NUM_W-1:0]   out_res_num,
  output logic [rfa_pkg::DEN_W-1:0]   out_res_den,
  output logic                        out_compare_true,
  output logic                        out_div_by_zero,
  output logic                        out_overflow
);

  localparam int PW = rfa_pkg::PROD_W;
  localparam int CW = $clog2(PW);

  rfa_pkg::back_state_t state_r, state_nxt;
  rfa_pkg::item_t       item_r, item_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW:0]          k_r, k_nxt;
  logic [PW-1:0]        p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [PW-1:0]        mn_r, mn_nxt, md_r, md_nxt;
  logic [PW-1:0]        u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [PW-1:0]        qn_r, qn_nxt, qd_r, qd_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic                 neg_r, neg_nxt;
  logic [rfa_pkg::NUM_W-1:0] rnum_r, rnum_nxt;
  logic [rfa_pkg::DEN_W-1:0] rden_r, rden_nxt;
  logic                 rcmp_r, rcmp_nxt, rdz_r, rdz_nxt, rovf_r, rovf_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [rfa_pkg::NUM_W-1:0] out_num_r, out_num_nxt;
  logic [rfa_pkg::DEN_W-1:0] out_den_r, out_den_nxt;
  logic                 out_cmp_r, out_cmp_nxt, out_dz_r, out_dz_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic signed [rfa_pkg::OPD_W-1:0]   mx, my;
  logic signed [2*rfa_pkg::OPD_W-1:0] prod;
  logic [PW-1:0]        n, d, n_mag, d_mag, rn_t, rd_t, mag_res;
  logic                 ovf;

  assign prod = mx * my;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    p0_nxt = p0_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    mn_nxt = mn_r;
    md_nxt = md_r;
    u_nxt = u_r;
    v_nxt = v_r;
    g_nxt = g_r;
    qn_nxt = qn_r;
    qd_nxt = qd_r;
    rn_nxt = rn_r;
    rd_nxt = rd_r;
    neg_nxt = neg_r;
    rnum_nxt = rnum_r;
    rden_nxt = rden_r;
    rcmp_nxt = rcmp_r;
    rdz_nxt = rdz_r;
    rovf_nxt = rovf_r;
    out_valid_nxt = out_valid_r;
    out_num_nxt = out_num_r;
    out_den_nxt = out_den_r;
    out_cmp_nxt = out_cmp_r;
    out_dz_nxt = out_dz_r;
    out_ovf_nxt = out_ovf_r;
    q_pop = 1'b0;

    mx = item_r.x0;
    my = item_r.y0;
    case (cnt_r[1:0])
      2'd1: begin
        mx = item_r.x1;
        my = item_r.y1;
      end
      2'd2: begin
        mx = item_r.x2;
        my = item_r.y2;
      end
      default: begin
      end
    endcase

    case (item_r.op)
      rfa_pkg::OP_ADD: n = p0_r + p1_r;
      rfa_pkg::OP_SUB: n = p0_r - p1_r;
      default:         n = p0_r;
    endcase
    d = p2_r;
    n_mag = n[PW-1] ? (~n + PW'(1)) : n;
    d_mag = d[PW-1] ? (~d + PW'(1)) : d;

    rn_t = {rn_r[PW-2:0], qn_r[PW-1]};
    rd_t = {rd_r[PW-2:0], qd_r[PW-1]};

    ovf = (md_r > rfa_pkg::LIMIT) ||
          (neg_r ? (qn_r > rfa_pkg::LIMIT + PW'(1)) : (qn_r > rfa_pkg::LIMIT));
    mag_res = neg_r ? (~qn_r + PW'(1)) : qn_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rfa_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          item_nxt = q_head;
          cnt_nxt = '0;
          state_nxt = rfa_pkg::ST_MUL;
        end
      end
      rfa_pkg::ST_MUL: begin
        case (cnt_r[1:0])
          2'd0:    p0_nxt = prod[PW-1:0];
          2'd1:    p1_nxt = prod[PW-1:0];
          default: p2_nxt = prod[PW-1:0];
        endcase
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r[1:0] == 2'd2) begin
          state_nxt = rfa_pkg::ST_PREP;
        end
      end
      rfa_pkg::ST_PREP: begin
        rnum_nxt = '0;
        rden_nxt = rfa_pkg::DEN_W'(1);
        rcmp_nxt = 1'b0;
        rdz_nxt = 1'b0;
        rovf_nxt = 1'b0;
        state_nxt = rfa_pkg::ST_DONE;
        case (item_r.op)
          rfa_pkg::OP_LT: rcmp_nxt = ($signed(p0_r) < $signed(p1_r));
          rfa_pkg::OP_LE: rcmp_nxt = ($signed(p0_r) <= $signed(p1_r));
          rfa_pkg::OP_EQ: rcmp_nxt = (p0_r == p1_r);
          default: begin
            if (item_r.div_zero) begin
              rnum_nxt = rfa_pkg::LIMIT[rfa_pkg::NUM_W-1:0];
              rdz_nxt = 1'b1;
            end else if (n_mag != '0) begin
              neg_nxt = n[PW-1] ^ d[PW-1];
              mn_nxt = n_mag;
              md_nxt = d_mag;
              u_nxt = n_mag;
              v_nxt = d_mag;
              k_nxt = '0;
              state_nxt = rfa_pkg::ST_GCD;
            end
          end
        endcase
      end
      rfa_pkg::ST_GCD: begin
        // One binary gcd step a cycle; common factors of two counted in k.
        if (u_r == '0 || v_r == '0) begin
          g_nxt = (u_r | v_r) << k_r;
          qn_nxt = mn_r;
          qd_nxt = md_r;
          rn_nxt = '0;
          rd_nxt = '0;
          cnt_nxt = '0;
          state_nxt = rfa_pkg::ST_DIV;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + (CW+1)'(1);
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = (u_r - v_r) >> 1;
        end else begin
          v_nxt = (v_r - u_r) >> 1;
        end
      end
      rfa_pkg::ST_DIV: begin
        // Both quotients by the gcd, one bit each per cycle.
        if (rn_t >= g_r) begin
          rn_nxt = rn_t - g_r;
          qn_nxt = {qn_r[PW-2:0], 1'b1};
        end else begin
          rn_nxt = rn_t;
          qn_nxt = {qn_r[PW-2:0], 1'b0};
        end
        if (rd_t >= g_r) begin
          rd_nxt = rd_t - g_r;
          qd_nxt = {qd_r[PW-2:0], 1'b1};
        end else begin
          rd_nxt = rd_t;
          qd_nxt = {qd_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = rfa_pkg::ST_FIN;
        end
      end
      rfa_pkg::ST_FIN: begin
        // md_r now holds the reduced denominator for the limit check.
        state_nxt = rfa_pkg::ST_DONE;
        rcmp_nxt = 1'b0;
        rdz_nxt = 1'b0;
        rovf_nxt = ovf;
        if (ovf) begin
          rnum_nxt = '0;
          rden_nxt = rfa_pkg::DEN_W'(1);
        end else begin
          rnum_nxt = mag_res[rfa_pkg::NUM_W-1:0];
          rden_nxt = qd_r[rfa_pkg::DEN_W-1:0];
        end
      end
      rfa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_num_nxt = rnum_r;
          out_den_nxt = rden_r;
          out_cmp_nxt = rcmp_r;
          out_dz_nxt = rdz_r;
          out_ovf_nxt = rovf_r;
          state_nxt = rfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rfa_pkg::ST_IDLE;
      end
    endcase

    if (state_r == rfa_pkg::ST_DIV && cnt_r == CW'(PW - 1)) begin
      md_nxt = qd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cnt_r <= cnt_nxt;
    k_r <= k_nxt;
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    mn_r <= mn_nxt;
    md_r <= md_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
    g_r <= g_nxt;
    qn_r <= qn_nxt;
    qd_r <= qd_nxt;
    rn_r <= rn_nxt;
    rd_r <= rd_nxt;
    neg_r <= neg_nxt;
    rnum_r <= rnum_nxt;
    rden_r <= rden_nxt;
    rcmp_r <= rcmp_nxt;
    rdz_r <= rdz_nxt;
    rovf_r <= rovf_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
    out_cmp_r <= out_cmp_nxt;
    out_dz_r <= out_dz_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_compare_true = out_cmp_r;
  assign out_div_by_zero = out_dz_r;
  assign out_overflow = out_ovf_r;

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rfa_pkg::ST_DIV |-> g_r != '0) else $error("zero divisor in reduction");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_dz_r && out_ovf_r)) else $error("both error flags set");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cmp_r) |-> (out_num_r == '0 && out_den_r == rfa_pkg::DEN_W'(1)))
    else $error("comparison result carries a fraction");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == rfa_pkg::ST_MUL) else $error("pop outside idle");

endmodule

>>> src/rational_fraction_alu.sv
// Rational fraction ALU: add, sub, mul, div, negate and compare of fractions.
// Comparisons and special cases skip the reduction; arithmetic runs the
// binary gcd loop, one step a cycle, then the 64 steps of the two parallel
// reduction dividers. The back end takes one item at a time;
// a two-entry queue absorbs input bursts.
// Reset (synchronous, active low) empties the queue and the result register.
module rational_fraction_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_kind,
  input  logic [rfa_pkg::NUM_W-1:0]   in_a_num,
  input  logic [rfa_pkg::DEN_W-1:0]   in_a_den,
  input  logic [rfa_pkg::NUM_W-1:0]   in_b_num,
  input  logic [rfa_pkg::DEN_W-1:0]   in_b_den,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rfa_pkg::NUM_W-1:0]   out_res_num,
  output logic [rfa_pkg::DEN_W-1:0]   out_res_den,
  output logic                        out_compare_true,
  output logic                        out_div_by_zero,
  output logic                        out_overflow
);

  // The front end decodes each item into three product operand pairs, so the
  // back end runs one shared multiplier for every operation.
  rfa_pkg::item_t front_item, head_item;
  logic           q_full, q_not_empty, q_pop, push;

  // An item is taken whenever the queue has room, independently of the
  // back end and of whether a result is waiting at the output.
  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  rfa_front u_front (
    .in_kind  (in_kind),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .item     (front_item)
  );

  rfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  // The back end forms the products, reduces by the gcd and holds the
  // finished item in its output register until it is taken.
  rfa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (head_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_div_by_zero  (out_div_by_zero),
    .out_overflow     (out_overflow)
  );

endmodule

>>> bench/rational_fraction_alu_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rational_fraction_alu: directed table, then random items.
// Depends on rfa_pkg and the rational_fraction_alu RTL only.
module rational_fraction_alu_tb;

  typedef struct {
    logic [rfa_pkg::NUM_W-1:0] res_num;
    logic [rfa_pkg::DEN_W-1:0] res_den;
    logic                      cmp;
    logic                      dbz;
    logic                      ovf;
  } frac_result_t;

  // One row of the directed table. Where typed is set, the expected result is
  // given in the row; otherwise the predictor supplies it.
  typedef struct {
    rfa_pkg::op_t              op;
    logic [rfa_pkg::NUM_W-1:0] a_num;
    logic [rfa_pkg::DEN_W-1:0] a_den;
    logic [rfa_pkg::NUM_W-1:0] b_num;
    logic [rfa_pkg::DEN_W-1:0] b_den;
    bit                        typed;
    frac_result_t              res;
  } directed_row_t;

  localparam logic [rfa_pkg::NUM_W-1:0] MAX_NUM = 32'h7FFF_FFFF;
  localparam logic [rfa_pkg::NUM_W-1:0] MIN_NUM = 32'h8000_0000;
  localparam logic [rfa_pkg::DEN_W-1:0] MAX_DEN = 31'h7FFF_FFFF;
  localparam int N_RANDOM = 1280;
  localparam int N_PHASES = 3;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                in_kind;
  logic [rfa_pkg::NUM_W-1:0] in_a_num;
  logic [rfa_pkg::DEN_W-1:0] in_a_den;
  logic [rfa_pkg::NUM_W-1:0] in_b_num;
  logic [rfa_pkg::DEN_W-1:0] in_b_den;
  logic                      out_valid;
  logic                      out_ready;
  logic [rfa_pkg::NUM_W-1:0] out_res_num;
  logic [rfa_pkg::DEN_W-1:0] out_res_den;
  logic                      out_compare_true;
  logic                      out_div_by_zero;
  logic                      out_overflow;

  frac_result_t pending_results[$];
  int           mismatches = 0;
  int           accepted_items = 0;
  int           idle_phase = 0;

  rational_fraction_alu dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_div_by_zero  (out_div_by_zero),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reduces n/d by the Euclidean gcd, makes the denominator positive and
  // flags a result that does not fit the port widths.
  function automatic frac_result_t reduce_fraction(longint n, longint d);
    frac_result_t r;
    bit           neg;
    logic [63:0]  mn, md, x, y, t, lim;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    lim = rfa_pkg::LIMIT;
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x != 0) begin
      mn = mn / x;
      md = md / x;
    end
    if (mn == 0) begin
      neg = 0;
      md = 1;
    end
    r.cmp = 0;
    r.dbz = 0;
    if (md > lim || (neg ? mn > lim + 1 : mn > lim)) begin
      r.res_num = '0;
      r.res_den = 1;
      r.ovf = 1;
    end else begin
      r.res_num = neg ? rfa_pkg::NUM_W'(-mn) : rfa_pkg::NUM_W'(mn);
      r.res_den = rfa_pkg::DEN_W'(md);
      r.ovf = 0;
    end
    return r;
  endfunction

  function automatic frac_result_t predict_fraction(rfa_pkg::op_t op,
                                                   logic [rfa_pkg::NUM_W-1:0] a_num,
                                                   logic [rfa_pkg::DEN_W-1:0] a_den,
                                                   logic [rfa_pkg::NUM_W-1:0] b_num,
                                                   logic [rfa_pkg::DEN_W-1:0] b_den);
    frac_result_t r;
    longint an, ad, bn, bd, lhs, rhs;
    an = longint'($signed(a_num));
    bn = longint'($signed(b_num));
    ad = longint'({33'd0, a_den});
    bd = longint'({33'd0, b_den});
    // A zero denominator is out of range and counts as one.
    if (ad == 0) ad = 1;
    if (bd == 0) bd = 1;
    r = '{res_num: '0, res_den: 1, cmp: 0, dbz: 0, ovf: 0};
    lhs = an * bd;
    rhs = bn * ad;
    case (op)
      rfa_pkg::OP_ADD: r = reduce_fraction(lhs + rhs, ad * bd);
      rfa_pkg::OP_SUB: r = reduce_fraction(lhs - rhs, ad * bd);
      rfa_pkg::OP_MUL: r = reduce_fraction(an * bn, ad * bd);
      rfa_pkg::OP_DIV: begin
        if (bn == 0) begin
          r.res_num = MAX_NUM;
          r.dbz = 1;
        end else begin
          r = reduce_fraction(lhs, ad * bn);
        end
      end
      rfa_pkg::OP_NEG: r = reduce_fraction(-an, ad);
      rfa_pkg::OP_LT:  r.cmp = lhs < rhs;
      rfa_pkg::OP_LE:  r.cmp = lhs <= rhs;
      default: r.cmp = lhs == rhs;
    endcase
    return r;
  endfunction

  function automatic logic [rfa_pkg::NUM_W-1:0] random_numerator();
    logic [rfa_pkg::NUM_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = rfa_pkg::NUM_W'($signed($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 3))
          0: v = MAX_NUM;
          1: v = MIN_NUM;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [rfa_pkg::DEN_W-1:0] random_denominator();
    logic [rfa_pkg::DEN_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = rfa_pkg::DEN_W'($urandom_range(1, 12));
      1: v = rfa_pkg::DEN_W'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: v = '0;
          1: v = 1;
          default: v = MAX_DEN;
        endcase
      end
      default: v = rfa_pkg::DEN_W'($urandom_range(1, 65535));
    endcase
    return v;
  endfunction

  // Presents one item at the falling edge and holds it until it is taken.
  // The sender idles at 10 in a hundred in the first phase and at 84 in a
  // hundred in the second.
  task automatic send_fraction_item(rfa_pkg::op_t op,
                                    logic [rfa_pkg::NUM_W-1:0] a_num,
                                    logic [rfa_pkg::DEN_W-1:0] a_den,
                                    logic [rfa_pkg::NUM_W-1:0] b_num,
                                    logic [rfa_pkg::DEN_W-1:0] b_den);
    int seen;
    int idle_pct;
    idle_pct = (idle_phase == 0) ? 10 : ((idle_phase == 1) ? 84 : 0);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= op;
    in_a_num <= a_num;
    in_a_den <= a_den;
    in_b_num <= b_num;
    in_b_den <= b_den;
    seen = accepted_items;
    do @(negedge clk); while (accepted_items == seen);
  endtask

  // The receiver stalls at 84 in a hundred in the first phase and at 10 in a
  // hundred in the second.
  always @(negedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(0, 99) >=
                    ((idle_phase == 0) ? 84 : ((idle_phase == 1) ? 10 : 0)));
  end

  // Input side: an accepted item gets its predicted result queued, unless
  // the directed table typed the expectation in already (see the stimulus).
  typedef struct {
    bit           typed;
    frac_result_t res;
  } typed_hint_t;
  typed_hint_t next_hint;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (next_hint.typed)
        pending_results.push_back(next_hint.res);
      else
        pending_results.push_back(predict_fraction(rfa_pkg::op_t'(in_kind), in_a_num,
                                                   in_a_den, in_b_num, in_b_den));
      accepted_items <= accepted_items + 1;
    end
  end

  // Result side: every accepted result is compared field by field with the
  // oldest expectation.
  always @(posedge clk) begin
    frac_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_res_num !== want.res_num) begin
          $error("res_num: expected %0d, got %0d", $signed(want.res_num),
                 $signed(out_res_num));
          mismatches++;
        end
        if (out_res_den !== want.res_den) begin
          $error("res_den: expected %0d, got %0d", want.res_den, out_res_den);
          mismatches++;
        end
        if (out_compare_true !== want.cmp) begin
          $error("compare_true: expected %0b, got %0b", want.cmp, out_compare_true);
          mismatches++;
        end
        if (out_div_by_zero !== want.dbz) begin
          $error("div_by_zero: expected %0b, got %0b", want.dbz, out_div_by_zero);
          mismatches++;
        end
        if (out_overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    directed_row_t directed[$];
    frac_result_t  zero_res, max_res, ovf_res, true_res, false_res;
    zero_res  = '{res_num: '0, res_den: 1, cmp: 0, dbz: 0, ovf: 0};
    max_res   = '{res_num: MAX_NUM, res_den: 1, cmp: 0, dbz: 1, ovf: 0};
    ovf_res   = '{res_num: '0, res_den: 1, cmp: 0, dbz: 0, ovf: 1};
    true_res  = '{res_num: '0, res_den: 1, cmp: 1, dbz: 0, ovf: 0};
    false_res = zero_res;

    // Directed table: the first rows carry results that are plain to see,
    // the rest lean on the predictor.
    directed = '{
      '{rfa_pkg::OP_ADD, '0, 1, '0, 1, 1, zero_res},
      '{rfa_pkg::OP_DIV, 32'd5, 31'd3, '0, 31'd7, 1, max_res},
      '{rfa_pkg::OP_DIV, MIN_NUM, MAX_DEN, '0, '0, 1, max_res},
      '{rfa_pkg::OP_NEG, MIN_NUM, 1, '0, 1, 1, ovf_res},
      '{rfa_pkg::OP_MUL, MAX_NUM, 1, 32'd2, 1, 1, ovf_res},
      '{rfa_pkg::OP_ADD, MAX_NUM, 1, MAX_NUM, 1, 1, ovf_res},
      '{rfa_pkg::OP_MUL, 32'd1, MAX_DEN, 32'd1, 31'd2, 1, ovf_res},
      '{rfa_pkg::OP_EQ, 32'd1, 31'd2, 32'd2, 31'd4, 1, true_res},
      '{rfa_pkg::OP_LT, 32'd1, 31'd2, 32'd1, 31'd2, 1, false_res},
      '{rfa_pkg::OP_LE, 32'd1, 31'd2, 32'd1, 31'd2, 1, true_res},
      '{rfa_pkg::OP_SUB, 32'd3, 31'd4, 32'd3, 31'd4, 1, zero_res},
      '{rfa_pkg::OP_ADD, 32'd1, 31'd6, 32'd1, 31'd3, 0, zero_res},
      '{rfa_pkg::OP_SUB, MIN_NUM, MAX_DEN, MAX_NUM, MAX_DEN, 0, zero_res},
      '{rfa_pkg::OP_MUL, MIN_NUM, 1, 32'hFFFF_FFFF, 1, 0, zero_res},
      '{rfa_pkg::OP_MUL, MIN_NUM, MAX_DEN, MIN_NUM, MAX_DEN, 0, zero_res},
      '{rfa_pkg::OP_DIV, 32'd4, 31'd6, -32'sd8, 31'd9, 0, zero_res},
      '{rfa_pkg::OP_DIV, MAX_NUM, '0, MIN_NUM, '0, 0, zero_res},
      '{rfa_pkg::OP_NEG, MAX_NUM, MAX_DEN, MIN_NUM, MAX_DEN, 0, zero_res},
      '{rfa_pkg::OP_NEG, -32'sd6, 31'd4, '0, 1, 0, zero_res},
      '{rfa_pkg::OP_LT, MIN_NUM, 1, MAX_NUM, 1, 0, zero_res},
      '{rfa_pkg::OP_LE, MAX_NUM, MAX_DEN, MIN_NUM, 1, 0, zero_res},
      '{rfa_pkg::OP_EQ, '1, '0, '1, 1, 0, zero_res},
      '{rfa_pkg::OP_ADD, MIN_NUM, 1, MIN_NUM, 1, 0, zero_res},
      '{rfa_pkg::OP_SUB, '0, MAX_DEN, '0, 31'd5, 0, zero_res}
    };

    in_valid  = 1'b0;
    in_kind   = '0;
    in_a_num  = '0;
    in_a_den  = 1;
    in_b_num  = '0;
    in_b_den  = 1;
    next_hint = '{typed: 0, res: zero_res};
    rst_n     = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      next_hint <= '{typed: directed[i].typed, res: directed[i].res};
      send_fraction_item(directed[i].op, directed[i].a_num, directed[i].a_den,
                         directed[i].b_num, directed[i].b_den);
    end
    next_hint <= '{typed: 0, res: zero_res};

    // Random items in three idling phases.
    for (int p = 0; p < N_PHASES; p++) begin
      idle_phase = p;
      for (int k = 0; k < N_RANDOM / N_PHASES; k++)
        send_fraction_item(rfa_pkg::op_t'($urandom_range(0, 7)), random_numerator(),
                           random_denominator(), random_numerator(),
                           random_denominator());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
